// File: design/tcm_pkg.sv
`timescale 1ns / 1ps

package tcm_pkg;

  localparam int NUM_PHASES    = 3;
  localparam int INTEGRAL_TRIP = 150;
  localparam int DEBOUNCE_SET  = 10;
  localparam int DEBOUNCE_BITS = 15;
  localparam int CFG_IDX_BITS  = 3;

  // register map of the configuration port
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_OFFSET_A  = 3'd0,
    CFG_OFFSET_B  = 3'd1,
    CFG_OFFSET_C  = 3'd2,
    CFG_RESTRICT  = 3'd3,
    CFG_OVERCURR  = 3'd4,
    CFG_SUM_LIMIT = 3'd5,
    CFG_BUS_LIMIT = 3'd6
  } cfg_idx_t;

  // peak selector codes
  typedef enum logic [3:0] {
    PK_POS_A    = 4'd0,
    PK_POS_B    = 4'd1,
    PK_POS_C    = 4'd2,
    PK_NEG_A    = 4'd3,
    PK_NEG_B    = 4'd4,
    PK_NEG_C    = 4'd5,
    PK_BUS      = 4'd6,
    PK_SUM_HIGH = 4'd7,
    PK_SUM_LOW  = 4'd8
  } peak_sel_t;

  // per-phase status handed from a lane to the merge stage
  typedef struct packed {
    logic over_restrict;
    logic trip;
  } lane_flags_t;

endpackage

// File: design/three_phase_current_monitor.sv
`timescale 1ns / 1ps

// three-phase current monitor: one request carries one set of phase A/B/C ADC
// samples (one per PWM period). Three identical phase lanes remove the zero
// offset, take the magnitude, update the per-phase positive/negative peaks and
// run the excess-current integrator (trip above 150, then cleared); a merge
// stage forms |a+b+c| and |a|+|b|+|c|, runs the imbalance and bus debounce
// counters (set past 10, clear when back at zero), holds the sticky phase
// alarm and picks the peak named by peak_select. Throughput is one request per
// clock: all state updates in the cycle of acceptance and the result is
// registered into a two-entry output queue, so a stalled consumer only holds
// off input once both queue entries are full. Configuration writes
// are always taken (cfg_ready tied high) and must only happen while idle.
module three_phase_current_monitor #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // sample requests
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SAMPLE_BITS-1:0]        in_sample_a,
  input  logic [SAMPLE_BITS-1:0]        in_sample_b,
  input  logic [SAMPLE_BITS-1:0]        in_sample_c,
  input  logic                          in_clear_gate,
  input  logic [3:0]                    in_peak_select,
  // results
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS:0]   out_current_a,
  output logic signed [SAMPLE_BITS:0]   out_current_b,
  output logic signed [SAMPLE_BITS:0]   out_current_c,
  output logic [SAMPLE_BITS+1:0]        out_phase_sum_abs,
  output logic [SAMPLE_BITS+1:0]        out_bus_current,
  output logic                          out_restrict_duty,
  output logic                          out_phase_alarm,
  output logic                          out_sum_alarm,
  output logic                          out_bus_alarm,
  output logic signed [SAMPLE_BITS+2:0] out_peak_value,
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcm_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [SAMPLE_BITS+1:0]        cfg_data
);

  localparam int W  = SAMPLE_BITS;
  localparam int NP = tcm_pkg::NUM_PHASES;
  // packed result: three currents, sum, bus, four flags, peak
  localparam int PW = 3 * (W + 1) + 2 * (W + 2) + 4 + (W + 3);

  // configuration registers
  logic [W-1:0]   offset_r [NP];
  logic [W-1:0]   restrict_lim_r;
  logic [W-1:0]   oc_lim_r;
  logic [W+1:0]   sum_lim_r;
  logic [W+1:0]   bus_lim_r;

  logic           in_acc;
  logic           out_acc;
  logic [W-1:0]   sample_v [NP];

  logic signed [W:0]    cur     [NP];
  logic [W-1:0]         mag     [NP];
  logic signed [W:0]    pos_pk  [NP];
  logic signed [W:0]    neg_pk  [NP];
  tcm_pkg::lane_flags_t flags   [NP];

  logic [W+1:0]         sum_abs;
  logic [W+1:0]         bus;
  logic                 restrict_any;
  logic                 phase_alarm, sum_alarm, bus_alarm;
  logic signed [W+2:0]  peak;

  // two-entry output queue
  logic [PW-1:0]  q_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;
  logic [PW-1:0]  result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r[0]    <= '0;
      offset_r[1]    <= '0;
      offset_r[2]    <= '0;
      restrict_lim_r <= W'(2000);
      oc_lim_r       <= W'(2000);
      sum_lim_r      <= (W+2)'(2000);
      bus_lim_r      <= (W+2)'(2000);
    end else if (cfg_valid) begin
      unique case (tcm_pkg::cfg_idx_t'(cfg_index))
        tcm_pkg::CFG_OFFSET_A:  offset_r[0]    <= cfg_data[W-1:0];
        tcm_pkg::CFG_OFFSET_B:  offset_r[1]    <= cfg_data[W-1:0];
        tcm_pkg::CFG_OFFSET_C:  offset_r[2]    <= cfg_data[W-1:0];
        tcm_pkg::CFG_RESTRICT:  restrict_lim_r <= cfg_data[W-1:0];
        tcm_pkg::CFG_OVERCURR:  oc_lim_r       <= cfg_data[W-1:0];
        tcm_pkg::CFG_SUM_LIMIT: sum_lim_r      <= cfg_data;
        tcm_pkg::CFG_BUS_LIMIT: bus_lim_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // accept whenever the queue has a free slot
  assign in_ready = (count_r != 2'd2);
  assign in_acc   = in_valid & in_ready;
  assign out_valid = (count_r != 2'd0);
  assign out_acc   = out_valid & out_ready;

  assign sample_v[0] = in_sample_a;
  assign sample_v[1] = in_sample_b;
  assign sample_v[2] = in_sample_c;

  // one lane per phase
  for (genvar i = 0; i < NP; i++) begin : g_lane
    tcm_lane #(.SAMPLE_BITS(W)) u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .en           (in_acc),
      .sample       (sample_v[i]),
      .offset       (offset_r[i]),
      .restrict_lim (restrict_lim_r),
      .oc_lim       (oc_lim_r),
      .cur          (cur[i]),
      .mag          (mag[i]),
      .pos_pk_nxt   (pos_pk[i]),
      .neg_pk_nxt   (neg_pk[i]),
      .flags        (flags[i])
    );
  end

  // combine what the lanes found
  tcm_merge #(.SAMPLE_BITS(W)) u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (in_acc),
    .cur          (cur),
    .mag          (mag),
    .pos_pk_nxt   (pos_pk),
    .neg_pk_nxt   (neg_pk),
    .flags        (flags),
    .clear_gate   (in_clear_gate),
    .peak_select  (in_peak_select),
    .sum_lim      (sum_lim_r),
    .bus_lim      (bus_lim_r),
    .sum_abs      (sum_abs),
    .bus          (bus),
    .restrict_any (restrict_any),
    .phase_alarm  (phase_alarm),
    .sum_alarm    (sum_alarm),
    .bus_alarm    (bus_alarm),
    .peak         (peak)
  );

  assign result = {cur[0], cur[1], cur[2], sum_abs, bus,
                   restrict_any, phase_alarm, sum_alarm, bus_alarm, peak};

  // queue storage, payload only
  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_r[wr_ptr_r] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (in_acc) wr_ptr_r <= ~wr_ptr_r;
      if (out_acc) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  assign {out_current_a, out_current_b, out_current_c, out_phase_sum_abs,
          out_bus_current, out_restrict_duty, out_phase_alarm, out_sum_alarm,
          out_bus_alarm, out_peak_value} = q_r[rd_ptr_r];

endmodule

// File: design/tcm_lane.sv
`timescale 1ns / 1ps

module tcm_lane #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic [SAMPLE_BITS-1:0]    sample,
  input  logic [SAMPLE_BITS-1:0]    offset,
  input  logic [SAMPLE_BITS-1:0]    restrict_lim,
  input  logic [SAMPLE_BITS-1:0]    oc_lim,
  output logic signed [SAMPLE_BITS:0] cur,
  output logic [SAMPLE_BITS-1:0]    mag,
  output logic signed [SAMPLE_BITS:0] pos_pk_nxt,
  output logic signed [SAMPLE_BITS:0] neg_pk_nxt,
  output tcm_pkg::lane_flags_t      flags
);

  localparam int W = SAMPLE_BITS;

  logic signed [W:0] neg_cur;
  logic signed [W:0] pos_pk_r;
  logic signed [W:0] neg_pk_r;
  logic [W:0]        integ_r;
  logic [W:0]        integ_nxt;
  logic [W-1:0]      excess;
  logic [W+1:0]      integ_sum;

  assign cur     = $signed({1'b0, sample}) - $signed({1'b0, offset});
  assign neg_cur = -cur;
  assign mag     = cur[W] ? neg_cur[W-1:0] : cur[W-1:0];

  assign pos_pk_nxt = (cur > pos_pk_r) ? cur : pos_pk_r;
  assign neg_pk_nxt = (cur < neg_pk_r) ? cur : neg_pk_r;

  assign excess    = mag - oc_lim;
  assign integ_sum = {1'b0, integ_r} + {2'b00, excess};

  always_comb begin
    flags.over_restrict = (mag > restrict_lim);
    flags.trip          = 1'b0;
    integ_nxt           = '0;
    if (mag > restrict_lim) begin
      if (mag > oc_lim) begin
        if (integ_sum > (W+2)'(tcm_pkg::INTEGRAL_TRIP)) begin
          flags.trip = 1'b1;
          integ_nxt  = '0;
        end else begin
          integ_nxt = integ_sum[W:0];
        end
      end else if (integ_r != '0) begin
        integ_nxt = integ_r - 1'b1;
      end else begin
        integ_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r  <= '0;
      pos_pk_r <= '0;
      neg_pk_r <= '0;
    end else if (en) begin
      integ_r  <= integ_nxt;
      pos_pk_r <= pos_pk_nxt;
      neg_pk_r <= neg_pk_nxt;
    end
  end

endmodule

// File: design/tcm_merge.sv
`timescale 1ns / 1ps

module tcm_merge #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic signed [SAMPLE_BITS:0]   cur        [tcm_pkg::NUM_PHASES],
  input  logic [SAMPLE_BITS-1:0]        mag        [tcm_pkg::NUM_PHASES],
  input  logic signed [SAMPLE_BITS:0]   pos_pk_nxt [tcm_pkg::NUM_PHASES],
  input  logic signed [SAMPLE_BITS:0]   neg_pk_nxt [tcm_pkg::NUM_PHASES],
  input  tcm_pkg::lane_flags_t          flags      [tcm_pkg::NUM_PHASES],
  input  logic                          clear_gate,
  input  logic [3:0]                    peak_select,
  input  logic [SAMPLE_BITS+1:0]        sum_lim,
  input  logic [SAMPLE_BITS+1:0]        bus_lim,
  output logic [SAMPLE_BITS+1:0]        sum_abs,
  output logic [SAMPLE_BITS+1:0]        bus,
  output logic                          restrict_any,
  output logic                          phase_alarm,
  output logic                          sum_alarm,
  output logic                          bus_alarm,
  output logic signed [SAMPLE_BITS+2:0] peak
);

  localparam int W  = SAMPLE_BITS;
  localparam int DB = tcm_pkg::DEBOUNCE_BITS;

  logic signed [W+2:0] sum_s;
  logic signed [W+2:0] sum_neg;
  logic                trip_any;
  logic [DB-1:0]       sum_db_r, sum_db_nxt;
  logic [DB-1:0]       bus_db_r, bus_db_nxt;
  logic                phase_alarm_r, sum_alarm_r, bus_alarm_r;
  logic [W+1:0]        bus_pk_r, bus_pk_nxt;
  logic [W+1:0]        sum_pk_r, sum_pk_nxt;

  assign sum_s   = (W+3)'(cur[0]) + (W+3)'(cur[1]) + (W+3)'(cur[2]);
  assign sum_neg = -sum_s;
  assign sum_abs = sum_s[W+2] ? sum_neg[W+1:0] : sum_s[W+1:0];
  assign bus     = (W+2)'(mag[0]) + (W+2)'(mag[1]) + (W+2)'(mag[2]);

  assign restrict_any = flags[0].over_restrict | flags[1].over_restrict
                      | flags[2].over_restrict;
  assign trip_any     = flags[0].trip | flags[1].trip | flags[2].trip;

  // up/down counter, saturating at full scale
  function automatic logic [DB:0] debounce(input logic [DB-1:0] cnt,
                                          input logic flag, input logic over);
    logic [DB-1:0] c;
    logic          f;
    c = cnt;
    f = flag;
    if (over) begin
      if (c != '1) c = c + 1'b1;
      if (c > DB'(tcm_pkg::DEBOUNCE_SET)) f = 1'b1;
    end else if (c != '0) begin
      c = c - 1'b1;
    end else begin
      f = 1'b0;
    end
    return {f, c};
  endfunction

  assign {sum_alarm, sum_db_nxt} = debounce(sum_db_r, sum_alarm_r, sum_abs >= sum_lim);
  assign {bus_alarm, bus_db_nxt} = debounce(bus_db_r, bus_alarm_r, bus >= bus_lim);

  always_comb begin
    if (trip_any) begin
      phase_alarm = 1'b1;
    end else if (clear_gate) begin
      phase_alarm = 1'b0;
    end else begin
      phase_alarm = phase_alarm_r;
    end
  end

  assign bus_pk_nxt = (bus > bus_pk_r) ? bus : bus_pk_r;
  assign sum_pk_nxt = (sum_abs > sum_pk_r) ? sum_abs : sum_pk_r;

  // low peak of |sum| starts at zero and can never drop below it
  always_comb begin
    unique case (tcm_pkg::peak_sel_t'(peak_select))
      tcm_pkg::PK_POS_A:    peak = (W+3)'(pos_pk_nxt[0]);
      tcm_pkg::PK_POS_B:    peak = (W+3)'(pos_pk_nxt[1]);
      tcm_pkg::PK_POS_C:    peak = (W+3)'(pos_pk_nxt[2]);
      tcm_pkg::PK_NEG_A:    peak = (W+3)'(neg_pk_nxt[0]);
      tcm_pkg::PK_NEG_B:    peak = (W+3)'(neg_pk_nxt[1]);
      tcm_pkg::PK_NEG_C:    peak = (W+3)'(neg_pk_nxt[2]);
      tcm_pkg::PK_BUS:      peak = $signed({1'b0, bus_pk_nxt});
      tcm_pkg::PK_SUM_HIGH: peak = $signed({1'b0, sum_pk_nxt});
      tcm_pkg::PK_SUM_LOW:  peak = '0;
      default:              peak = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_db_r      <= '0;
      bus_db_r      <= '0;
      phase_alarm_r <= 1'b0;
      sum_alarm_r   <= 1'b0;
      bus_alarm_r   <= 1'b0;
      bus_pk_r      <= '0;
      sum_pk_r      <= '0;
    end else if (en) begin
      sum_db_r      <= sum_db_nxt;
      bus_db_r      <= bus_db_nxt;
      phase_alarm_r <= phase_alarm;
      sum_alarm_r   <= sum_alarm;
      bus_alarm_r   <= bus_alarm;
      bus_pk_r      <= bus_pk_nxt;
      sum_pk_r      <= sum_pk_nxt;
    end
  end

endmodule

// File: design/tcm_checker.sv
`timescale 1ns / 1ps

module tcm_checker #(
  parameter int SAMPLE_BITS = 12
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS:0]   out_current_a,
  input logic signed [SAMPLE_BITS:0]   out_current_b,
  input logic signed [SAMPLE_BITS:0]   out_current_c,
  input logic [SAMPLE_BITS+1:0]        out_phase_sum_abs,
  input logic [SAMPLE_BITS+1:0]        out_bus_current
);

  localparam int W = SAMPLE_BITS;

  logic [W+1:0] mag_sum;

  function automatic logic [W+1:0] mag_of(input logic signed [W:0] v);
    logic signed [W:0] n;
    n = -v;
    return v[W] ? (W+2)'(n[W-1:0]) : (W+2)'(v[W-1:0]);
  endfunction

  assign mag_sum = mag_of(out_current_a) + mag_of(out_current_b)
                 + mag_of(out_current_c);

  // result queue comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_bus_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bus_current == mag_sum)
    else $error("bus current does not match phase magnitudes");

  a_bus_ge_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bus_current >= out_phase_sum_abs)
    else $error("phase sum exceeds bus current");

endmodule

bind three_phase_current_monitor tcm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_tcm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_current_a     (out_current_a),
  .out_current_b     (out_current_b),
  .out_current_c     (out_current_c),
  .out_phase_sum_abs (out_phase_sum_abs),
  .out_bus_current   (out_bus_current)
);

// File: tb/sv/three_phase_current_monitor_test.sv
`timescale 1ns / 1ps

module three_phase_current_monitor_test;

  localparam int SAMPLE_BITS   = 12;
  localparam int NUM_PHASES    = tcm_pkg::NUM_PHASES;
  localparam int INTEGRAL_TRIP = tcm_pkg::INTEGRAL_TRIP;
  localparam int DEBOUNCE_SET  = tcm_pkg::DEBOUNCE_SET;
  localparam int DEBOUNCE_BITS = tcm_pkg::DEBOUNCE_BITS;
  localparam int CFG_IDX_BITS  = tcm_pkg::CFG_IDX_BITS;
  localparam int CODE_MAX      = (1 << SAMPLE_BITS) - 1;
  localparam int LIMIT_MAX     = 3 * CODE_MAX;
  localparam int DEBOUNCE_MAX  = (1 << DEBOUNCE_BITS) - 1;
  localparam int CLK_PERIOD    = 4;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 100;
  localparam int CYCLE_LIMIT   = 200000;

  // one monitor reading as it leaves the block
  typedef struct packed {
    logic signed [SAMPLE_BITS:0]   current_a;
    logic signed [SAMPLE_BITS:0]   current_b;
    logic signed [SAMPLE_BITS:0]   current_c;
    logic [SAMPLE_BITS+1:0]        phase_sum_abs;
    logic [SAMPLE_BITS+1:0]        bus_current;
    logic                          duty_restricted;
    logic                          phase_alarm;
    logic                          sum_alarm;
    logic                          bus_alarm;
    logic signed [SAMPLE_BITS+2:0] peak_value;
  } reading_t;

  // one line of the directed script: a register write or a sample request
  typedef struct {
    bit                      is_write;
    logic [CFG_IDX_BITS-1:0] reg_idx;
    logic [SAMPLE_BITS+1:0]  reg_data;
    logic [SAMPLE_BITS-1:0]  sample_a;
    logic [SAMPLE_BITS-1:0]  sample_b;
    logic [SAMPLE_BITS-1:0]  sample_c;
    bit                      gate;
    logic [3:0]              select;
    bit                      typed;
    reading_t                literal;
  } script_row_t;

  // how the random part shapes the phase currents during a run
  typedef enum int {
    DRIVE_QUIET,
    DRIVE_LIMIT,
    DRIVE_HEAVY,
    DRIVE_NOISE
  } drive_mode_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [SAMPLE_BITS-1:0]        in_sample_a;
  logic [SAMPLE_BITS-1:0]        in_sample_b;
  logic [SAMPLE_BITS-1:0]        in_sample_c;
  logic                          in_clear_gate;
  logic [3:0]                    in_peak_select;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [SAMPLE_BITS:0]   out_current_a;
  logic signed [SAMPLE_BITS:0]   out_current_b;
  logic signed [SAMPLE_BITS:0]   out_current_c;
  logic [SAMPLE_BITS+1:0]        out_phase_sum_abs;
  logic [SAMPLE_BITS+1:0]        out_bus_current;
  logic                          out_restrict_duty;
  logic                          out_phase_alarm;
  logic                          out_sum_alarm;
  logic                          out_bus_alarm;
  logic signed [SAMPLE_BITS+2:0] out_peak_value;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [CFG_IDX_BITS-1:0]       cfg_index;
  logic [SAMPLE_BITS+1:0]        cfg_data;

  // shadow copy of the register file
  logic [SAMPLE_BITS-1:0] zero_offset [3];
  logic [SAMPLE_BITS-1:0] restrict_lim;
  logic [SAMPLE_BITS-1:0] overcurrent_lim;
  logic [SAMPLE_BITS+1:0] sum_lim;
  logic [SAMPLE_BITS+1:0] bus_lim;

  // shadow copy of the monitor state
  logic [SAMPLE_BITS:0]          excess [3];
  logic [DEBOUNCE_BITS-1:0]      sum_count;
  logic [DEBOUNCE_BITS-1:0]      bus_count;
  logic                          phase_flag;
  logic                          sum_flag;
  logic                          bus_flag;
  logic signed [SAMPLE_BITS:0]   high_peak [3];
  logic signed [SAMPLE_BITS:0]   low_peak [3];
  logic [SAMPLE_BITS+1:0]        bus_high_peak;
  logic [SAMPLE_BITS+1:0]        sum_high_peak;
  logic [SAMPLE_BITS+1:0]        sum_low_peak;

  reading_t    pending_readings [$];
  script_row_t script [$];
  int          mismatches;
  int          cycle_count;
  int          burst_left;
  bit          sender_idles;
  bit          receiver_stalls;
  logic [31:0] stall_pattern;
  int          stall_tick;

  three_phase_current_monitor #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_a      (in_sample_a),
    .in_sample_b      (in_sample_b),
    .in_sample_c      (in_sample_c),
    .in_clear_gate    (in_clear_gate),
    .in_peak_select   (in_peak_select),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_current_a    (out_current_a),
    .out_current_b    (out_current_b),
    .out_current_c    (out_current_c),
    .out_phase_sum_abs(out_phase_sum_abs),
    .out_bus_current  (out_bus_current),
    .out_restrict_duty(out_restrict_duty),
    .out_phase_alarm  (out_phase_alarm),
    .out_sum_alarm    (out_sum_alarm),
    .out_bus_alarm    (out_bus_alarm),
    .out_peak_value   (out_peak_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // up/down debounce: counts up on an over-limit sample (saturating), sets the
  // alarm past the threshold, counts down otherwise and clears only at zero
  function automatic logic [DEBOUNCE_BITS:0] debounce_next(logic [DEBOUNCE_BITS-1:0] count,
                                                           logic flag, bit over);
    if (over) begin
      if (count != DEBOUNCE_MAX) count = count + 1'b1;
      if (count > DEBOUNCE_SET) flag = 1'b1;
    end else if (count != '0) begin
      count = count - 1'b1;
    end else begin
      flag = 1'b0;
    end
    return {flag, count};
  endfunction

  // advances the shadow state by one sample request and returns the reading
  function automatic reading_t predict_reading(logic [SAMPLE_BITS-1:0] sample_a,
                                               logic [SAMPLE_BITS-1:0] sample_b,
                                               logic [SAMPLE_BITS-1:0] sample_c,
                                               logic gate, logic [3:0] select);
    int       cur [3];
    int       mag;
    int       integral;
    int       sum;
    int       bus;
    int       peak;
    bit       any_restrict;
    bit       trip;
    reading_t r;
    cur[0] = int'(sample_a) - int'(zero_offset[0]);
    cur[1] = int'(sample_b) - int'(zero_offset[1]);
    cur[2] = int'(sample_c) - int'(zero_offset[2]);
    sum = 0;
    bus = 0;
    peak = 0;
    any_restrict = 1'b0;
    trip = 1'b0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      mag = (cur[p] < 0) ? -cur[p] : cur[p];
      if (cur[p] > high_peak[p]) high_peak[p] = cur[p][SAMPLE_BITS:0];
      if (cur[p] < low_peak[p]) low_peak[p] = cur[p][SAMPLE_BITS:0];
      sum += cur[p];
      bus += mag;
      // the integrator only runs while the phase is also over the restrict limit
      if (mag > int'(restrict_lim)) begin
        any_restrict = 1'b1;
        if (mag > int'(overcurrent_lim)) begin
          integral = int'(excess[p]) + mag - int'(overcurrent_lim);
          if (integral > INTEGRAL_TRIP) begin
            integral = 0;
            trip = 1'b1;
          end
          excess[p] = integral[SAMPLE_BITS:0];
        end else if (excess[p] != '0) begin
          excess[p] = excess[p] - 1'b1;
        end
      end else begin
        excess[p] = '0;
      end
    end
    if (sum < 0) sum = -sum;
    {sum_flag, sum_count} = debounce_next(sum_count, sum_flag, sum >= int'(sum_lim));
    {bus_flag, bus_count} = debounce_next(bus_count, bus_flag, bus >= int'(bus_lim));
    if (trip) phase_flag = 1'b1;
    else if (gate) phase_flag = 1'b0;
    if (bus > int'(bus_high_peak)) bus_high_peak = bus[SAMPLE_BITS+1:0];
    if (sum > int'(sum_high_peak)) sum_high_peak = sum[SAMPLE_BITS+1:0];
    if (sum < int'(sum_low_peak)) sum_low_peak = sum[SAMPLE_BITS+1:0];
    case (select)
      tcm_pkg::PK_POS_A:    peak = high_peak[0];
      tcm_pkg::PK_POS_B:    peak = high_peak[1];
      tcm_pkg::PK_POS_C:    peak = high_peak[2];
      tcm_pkg::PK_NEG_A:    peak = low_peak[0];
      tcm_pkg::PK_NEG_B:    peak = low_peak[1];
      tcm_pkg::PK_NEG_C:    peak = low_peak[2];
      tcm_pkg::PK_BUS:      peak = int'(bus_high_peak);
      tcm_pkg::PK_SUM_HIGH: peak = int'(sum_high_peak);
      tcm_pkg::PK_SUM_LOW:  peak = int'(sum_low_peak);
      default:              peak = 0;
    endcase
    r.current_a       = cur[0][SAMPLE_BITS:0];
    r.current_b       = cur[1][SAMPLE_BITS:0];
    r.current_c       = cur[2][SAMPLE_BITS:0];
    r.phase_sum_abs   = sum[SAMPLE_BITS+1:0];
    r.bus_current     = bus[SAMPLE_BITS+1:0];
    r.duty_restricted = any_restrict;
    r.phase_alarm     = phase_flag;
    r.sum_alarm       = sum_flag;
    r.bus_alarm       = bus_flag;
    r.peak_value      = peak[SAMPLE_BITS+2:0];
    return r;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] clamp_code(int code);
    if (code < 0) return '0;
    if (code > CODE_MAX) return CODE_MAX[SAMPLE_BITS-1:0];
    return code[SAMPLE_BITS-1:0];
  endfunction

  function automatic void script_write(tcm_pkg::cfg_idx_t idx, int data);
    script_row_t row;
    row = '{default: '0};
    row.is_write = 1'b1;
    row.reg_idx = idx;
    row.reg_data = data[SAMPLE_BITS+1:0];
    script.push_back(row);
  endfunction

  function automatic void script_sample(int a, int b, int c, bit gate, logic [3:0] select,
                                        bit typed, reading_t literal);
    script_row_t row;
    row = '{default: '0};
    row.sample_a = a[SAMPLE_BITS-1:0];
    row.sample_b = b[SAMPLE_BITS-1:0];
    row.sample_c = c[SAMPLE_BITS-1:0];
    row.gate = gate;
    row.select = select;
    row.typed = typed;
    row.literal = literal;
    script.push_back(row);
  endfunction

  task automatic check_field(string name, integer want, integer got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // one register write request; the shadow registers follow at acceptance
  task automatic write_register(tcm_pkg::cfg_idx_t idx, int data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[SAMPLE_BITS+1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tcm_pkg::CFG_OFFSET_A:  zero_offset[0] = data[SAMPLE_BITS-1:0];
      tcm_pkg::CFG_OFFSET_B:  zero_offset[1] = data[SAMPLE_BITS-1:0];
      tcm_pkg::CFG_OFFSET_C:  zero_offset[2] = data[SAMPLE_BITS-1:0];
      tcm_pkg::CFG_RESTRICT:  restrict_lim = data[SAMPLE_BITS-1:0];
      tcm_pkg::CFG_OVERCURR:  overcurrent_lim = data[SAMPLE_BITS-1:0];
      tcm_pkg::CFG_SUM_LIMIT: sum_lim = data[SAMPLE_BITS+1:0];
      tcm_pkg::CFG_BUS_LIMIT: bus_lim = data[SAMPLE_BITS+1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one sample request; bursts of back-to-back requests with random gaps
  // between them when the sender is set to idle
  task automatic send_sample(logic [SAMPLE_BITS-1:0] a, logic [SAMPLE_BITS-1:0] b,
                             logic [SAMPLE_BITS-1:0] c, bit gate, logic [3:0] select,
                             bit typed, reading_t literal);
    int       gap;
    reading_t forecast;
    if (sender_idles && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_sample_a <= a;
    in_sample_b <= b;
    in_sample_c <= c;
    in_clear_gate <= gate;
    in_peak_select <= select;
    do @(posedge clk); while (!in_ready);
    forecast = predict_reading(a, b, c, gate, select);
    // typed rows check the block against the hand-read value instead
    pending_readings.push_back(typed ? literal : forecast);
  endtask

  // drop valid, let every reading drain and give the pipe time to settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver back-pressure: a rotating random pattern, reloaded now and then,
  // sometimes dense and sometimes sparse in ready cycles
  always @(negedge clk) begin
    stall_tick++;
    if (stall_tick % 32 == 0) begin
      if ($urandom_range(0, 3) == 0) stall_pattern = $urandom & $urandom;
      else stall_pattern = $urandom | $urandom;
    end else begin
      stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
    end
    out_ready <= !receiver_stalls || stall_pattern[0];
  end

  // compare every accepted reading with the oldest one still pending
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        $display("%0t ns: reading with no request pending, expected none, got %0d/%0d/%0d",
                 $time, out_current_a, out_current_b, out_current_c);
        mismatches++;
      end else begin
        want = pending_readings.pop_front();
        check_field("current_a", $signed(want.current_a), out_current_a);
        check_field("current_b", $signed(want.current_b), out_current_b);
        check_field("current_c", $signed(want.current_c), out_current_c);
        check_field("phase_sum_abs", want.phase_sum_abs, out_phase_sum_abs);
        check_field("bus_current", want.bus_current, out_bus_current);
        check_field("restrict_duty", want.duty_restricted, out_restrict_duty);
        check_field("phase_alarm", want.phase_alarm, out_phase_alarm);
        check_field("sum_alarm", want.sum_alarm, out_sum_alarm);
        check_field("bus_alarm", want.bus_alarm, out_bus_alarm);
        check_field("peak_value", $signed(want.peak_value), out_peak_value);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("three_phase_current_monitor verification failed");
      $finish;
    end
  end

  initial begin
    int          run_left;
    int          run_sign;
    int          code [3];
    int          mag;
    int          lim;
    drive_mode_t mode;
    logic [3:0]  select;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_a = '0;
    in_sample_b = '0;
    in_sample_c = '0;
    in_clear_gate = 1'b0;
    in_peak_select = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    cycle_count = 0;
    burst_left = 0;
    sender_idles = 1'b0;
    receiver_stalls = 1'b1;
    stall_pattern = $urandom;
    stall_tick = 0;
    run_left = 0;
    run_sign = 1;
    mode = DRIVE_QUIET;

    // register and state values after reset
    for (int p = 0; p < NUM_PHASES; p++) begin
      zero_offset[p] = '0;
      excess[p] = '0;
      high_peak[p] = '0;
      low_peak[p] = '0;
    end
    restrict_lim = 12'd2000;
    overcurrent_lim = 12'd2000;
    sum_lim = 14'd2000;
    bus_lim = 14'd2000;
    sum_count = '0;
    bus_count = '0;
    phase_flag = 1'b0;
    sum_flag = 1'b0;
    bus_flag = 1'b0;
    bus_high_peak = '0;
    sum_high_peak = '0;
    sum_low_peak = '0;

    // directed script, reset register values first
    // all-zero samples: everything reads zero
    script_sample(0, 0, 0, 1'b0, tcm_pkg::PK_POS_A, 1'b1, '0);
    // full-scale phase A trips the integrator at once, debouncers only start
    script_sample(CODE_MAX, 0, 0, 1'b0, tcm_pkg::PK_POS_A, 1'b1,
                  reading_t'{13'sd4095, 13'sd0, 13'sd0, 14'd4095, 14'd4095,
                             1'b1, 1'b1, 1'b0, 1'b0, 15'sd4095});
    script_sample(0, CODE_MAX, 0, 1'b1, tcm_pkg::PK_POS_B, 1'b0, '0);
    script_sample(0, 0, CODE_MAX, 1'b1, tcm_pkg::PK_POS_C, 1'b0, '0);
    // no trip with the gate open: sticky phase alarm clears
    script_sample(0, 0, 0, 1'b1, tcm_pkg::PK_BUS, 1'b0, '0);
    script_sample(2001, 0, 0, 1'b0, tcm_pkg::PK_SUM_HIGH, 1'b0, '0);
    // low sum peak never moves off zero
    script_sample(1000, 1000, 1000, 1'b0, tcm_pkg::PK_SUM_LOW, 1'b0, '0);
    // unused selector
    script_sample(2000, 2000, 2000, 1'b1, 4'd9, 1'b0, '0);
    // top offsets and limits, restrict at zero: currents are never positive
    script_write(tcm_pkg::CFG_OFFSET_A, CODE_MAX);
    script_write(tcm_pkg::CFG_OFFSET_B, CODE_MAX);
    script_write(tcm_pkg::CFG_OFFSET_C, CODE_MAX);
    script_write(tcm_pkg::CFG_RESTRICT, 0);
    script_write(tcm_pkg::CFG_OVERCURR, CODE_MAX);
    script_write(tcm_pkg::CFG_SUM_LIMIT, LIMIT_MAX);
    script_write(tcm_pkg::CFG_BUS_LIMIT, LIMIT_MAX);
    // mostly restricted but never over the overcurrent limit: no phase can trip
    script_sample(0, 0, 0, 1'b0, tcm_pkg::PK_NEG_A, 1'b0, '0);
    script_sample(CODE_MAX, CODE_MAX, CODE_MAX, 1'b1, tcm_pkg::PK_NEG_B, 1'b0, '0);
    script_sample(2048, 1, 4094, 1'b0, tcm_pkg::PK_NEG_C, 1'b0, '0);
    script_sample(0, CODE_MAX, 0, 1'b1, 4'd15, 1'b0, '0);
    // mid-scale offsets, restrict never reached, limits at zero
    script_write(tcm_pkg::CFG_OFFSET_A, 2048);
    script_write(tcm_pkg::CFG_OFFSET_B, 2048);
    script_write(tcm_pkg::CFG_OFFSET_C, 2048);
    script_write(tcm_pkg::CFG_RESTRICT, CODE_MAX);
    script_write(tcm_pkg::CFG_OVERCURR, 0);
    script_write(tcm_pkg::CFG_SUM_LIMIT, 0);
    script_write(tcm_pkg::CFG_BUS_LIMIT, 0);
    script_sample(12'hAAA, 12'h555, 12'hFFF, 1'b0, tcm_pkg::PK_BUS, 1'b0, '0);
    script_sample(12'h555, 12'hAAA, 12'h000, 1'b1, tcm_pkg::PK_SUM_HIGH, 1'b0, '0);
    script_sample(2048, 2048, 2048, 1'b1, tcm_pkg::PK_SUM_LOW, 1'b0, '0);
    script_sample(0, 2048, CODE_MAX, 1'b0, tcm_pkg::PK_NEG_A, 1'b0, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_write) begin
        if (i == 0 || !script[i - 1].is_write) wait_idle();
        write_register(tcm_pkg::cfg_idx_t'(script[i].reg_idx), script[i].reg_data);
      end else begin
        send_sample(script[i].sample_a, script[i].sample_b, script[i].sample_c,
                    script[i].gate, script[i].select, script[i].typed, script[i].literal);
      end
    end

    // random phases: fresh register values each time, sender and receiver
    // idling switched on and off so that some phases run flat out
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      sender_idles = phase[0];
      receiver_stalls = phase[1];
      for (int p = 0; p < NUM_PHASES; p++) begin
        case ($urandom_range(0, 5))
          0:       lim = 0;
          1:       lim = CODE_MAX;
          2:       lim = $urandom_range(0, CODE_MAX);
          default: lim = 2048 + int'($urandom_range(0, 400)) - 200;
        endcase
        write_register(tcm_pkg::cfg_idx_t'(int'(tcm_pkg::CFG_OFFSET_A) + p), lim);
      end
      case ($urandom_range(0, 5))
        0:       lim = 0;
        1:       lim = CODE_MAX;
        default: lim = $urandom_range(200, 3000);
      endcase
      write_register(tcm_pkg::CFG_RESTRICT, lim);
      case ($urandom_range(0, 5))
        0:       lim = 0;
        1:       lim = CODE_MAX;
        2:       lim = $urandom_range(0, CODE_MAX);
        default: lim = clamp_code(int'(restrict_lim) + int'($urandom_range(0, 300)));
      endcase
      write_register(tcm_pkg::CFG_OVERCURR, lim);
      for (int k = 0; k < 2; k++) begin
        case ($urandom_range(0, 5))
          0:       lim = 0;
          1:       lim = LIMIT_MAX;
          2:       lim = $urandom_range(0, LIMIT_MAX);
          default: lim = $urandom_range(100, 4000);
        endcase
        write_register(k == 0 ? tcm_pkg::CFG_SUM_LIMIT : tcm_pkg::CFG_BUS_LIMIT, lim);
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // runs of one drive style so that integrators and debouncers build up
        if (run_left == 0) begin
          mode = drive_mode_t'($urandom_range(0, 3));
          run_left = $urandom_range(1, 40);
          run_sign = $urandom_range(0, 1) ? 1 : -1;
        end
        run_left--;
        for (int p = 0; p < NUM_PHASES; p++) begin
          case (mode)
            DRIVE_QUIET: begin
              code[p] = int'(zero_offset[p]) + int'($urandom_range(0, 80)) - 40;
            end
            DRIVE_LIMIT: begin
              // hover around the overcurrent limit, mostly one sign per run
              mag = int'(overcurrent_lim) + int'($urandom_range(0, 60)) - 20;
              if ($urandom_range(0, 4) == 0) mag = int'($urandom_range(0, 40));
              if ($urandom_range(0, 4) == 0) mag = -mag * run_sign;
              else mag = mag * run_sign;
              code[p] = int'(zero_offset[p]) + mag;
            end
            DRIVE_HEAVY: begin
              code[p] = int'(zero_offset[p]) + int'($urandom_range(0, 2 * CODE_MAX)) - CODE_MAX;
            end
            default: begin
              code[p] = $urandom_range(0, CODE_MAX);
            end
          endcase
        end
        if ($urandom_range(0, 6) == 0) select = 4'($urandom_range(9, 15));
        else select = 4'($urandom_range(0, 8));
        send_sample(clamp_code(code[0]), clamp_code(code[1]), clamp_code(code[2]),
                    $urandom_range(0, 3) == 0, select, 1'b0, '0);
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("three_phase_current_monitor verification clean");
    end else begin
      $display("three_phase_current_monitor verification failed");
    end
    $finish;
  end

endmodule

// File: three_phase_current_monitor.f
design/tcm_pkg.sv
design/tcm_lane.sv
design/tcm_merge.sv
design/three_phase_current_monitor.sv
design/tcm_checker.sv
tb/sv/three_phase_current_monitor_test.sv
